@@ hw/rtl/vn_pkg.sv @@
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants for the 4D vector normalizer
// Payload structs, pipeline side-band struct and the step counts of the
// square-root and divider pipelines.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int LANES      = 4;
    localparam int COMP_W     = 32;
    localparam int SQ_W       = 2 * COMP_W;        // one square
    localparam int SUM_W      = SQ_W + 1;          // sum of four squares
    localparam int RAD_W      = SUM_W + 1;         // radicand padded to even width
    localparam int ROOT_W     = RAD_W / 2;         // 33 result bits
    localparam int ROOT_STEPS = ROOT_W;
    localparam int SREM_W     = ROOT_W + 2;        // square-root partial remainder
    localparam int QUO_W      = 31;                // quotient bits, unit magnitude <= 2^30
    localparam int DREM_W     = ROOT_W;            // divider remainder, below the length
    localparam int DIV_STEPS  = QUO_W;
    localparam int MAG_W      = 33;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
    } t_vec_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] unit_x;
        logic signed [COMP_W-1:0] unit_y;
        logic signed [COMP_W-1:0] unit_z;
        logic signed [COMP_W-1:0] unit_w;
        logic        [MAG_W-1:0]  magnitude;
        logic                     zero_length;
    } t_vec_out;

    // Component magnitudes and signs that ride along with the length.
    typedef struct packed {
        logic [LANES-1:0][COMP_W-1:0] mag;
        logic [LANES-1:0]             neg;
    } t_side;

endpackage

@@ hw/rtl/vector4_normalize.sv @@
// ----------------------------------------------------------------------------
// vector4_normalize: Euclidean length and unit vector of a 4D vector
// Fixed-point normalizer: Q16.16 components in, Q17.16 length and Q2.30
// unit components out, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel | ports                 | transfer when
//   --------+-----------------------+-----------------------------
//   input   | start, busy, i_vec    | start high and busy low
//   result  | o_valid, o_res        | o_valid high (one cycle)
//
// Every item passes from the accepting edge to its result through the
// square and sum stages, 33 square-root stages (one root bit each), 31
// divider stages (one quotient bit each) and an output register.
// A new item may be accepted in every cycle, so busy is always low.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so no stage ever holds.
//
module vector4_normalize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vn_pkg::t_vec_in   i_vec,
    output logic              o_valid,
    output vn_pkg::t_vec_out  o_res
);
    import vn_pkg::*;

    logic              sq_valid;
    t_side             sq_side;
    logic [SUM_W-1:0]  sq_sum;
    logic              rt_valid;
    t_side             rt_side;
    logic [ROOT_W-1:0] rt_root;

    // The pipeline never holds, so every start is a transfer.
    assign busy = 1'b0;

    // Magnitudes, squares and their exact 65-bit sum.
    vn_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_vec   (i_vec),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_sum   (sq_sum)
    );

    // Truncated square root gives the length.
    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_sum   (sq_sum),
        .o_valid (rt_valid),
        .o_side  (rt_side),
        .o_root  (rt_root)
    );

    // Each magnitude times 2^30 over the length, then the sign goes back on.
    vn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rt_valid),
        .i_side  (rt_side),
        .i_root  (rt_root),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // The flag and the length must agree.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.zero_length == (o_res.magnitude == '0)))
        else $error("zero_length disagrees with magnitude");

    // A zero vector comes out as all zeros.
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.zero_length) |->
        (o_res.unit_x == '0 && o_res.unit_y == '0 &&
         o_res.unit_z == '0 && o_res.unit_w == '0))
        else $error("zero vector produced nonzero unit components");

    // The length never exceeds 2^32.
    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.magnitude <= {1'b1, 32'h0}))
        else $error("magnitude out of range");

    // The square root stage emits no item that was not summed before it.
    a_root_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rt_valid && $past(i_rst_n, ROOT_STEPS)) |-> $past(sq_valid, ROOT_STEPS))
        else $error("square root pipeline produced an unexpected item");
`endif

endmodule

@@ hw/rtl/vn_square.sv @@
// ----------------------------------------------------------------------------
// vn_square: component magnitudes and sum of squares
// Four stages: absolute value, square, pairwise add, final add.
// ----------------------------------------------------------------------------
module vn_square (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  vn_pkg::t_vec_in       i_vec,
    output logic                  o_valid,
    output vn_pkg::t_side         o_side,
    output logic [vn_pkg::SUM_W-1:0] o_sum
);
    import vn_pkg::*;

    logic [LANES-1:0][COMP_W-1:0] n_comp;
    logic                         r_v1, r_v2, r_v3, r_v4;
    t_side                        r_side1, r_side2, r_side3, r_side4;
    logic [LANES-1:0][SQ_W-1:0]   r_sq;
    logic [1:0][SQ_W:0]           r_pair;
    logic [SUM_W-1:0]             r_sum;

    assign n_comp = {i_vec.comp_x, i_vec.comp_y, i_vec.comp_z, i_vec.comp_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_side1.neg[l] <= n_comp[l][COMP_W-1];
            r_side1.mag[l] <= n_comp[l][COMP_W-1] ? (~n_comp[l] + 1'b1) : n_comp[l];
            r_sq[l]        <= SQ_W'(r_side1.mag[l]) * SQ_W'(r_side1.mag[l]);
        end
        r_pair[0] <= {1'b0, r_sq[0]} + {1'b0, r_sq[1]};
        r_pair[1] <= {1'b0, r_sq[2]} + {1'b0, r_sq[3]};
        r_sum     <= r_pair[0] + r_pair[1];
        r_side2   <= r_side1;
        r_side3   <= r_side2;
        r_side4   <= r_side3;
    end

    assign o_valid = r_v4;
    assign o_side  = r_side4;
    assign o_sum   = r_sum;

endmodule

@@ hw/rtl/vn_sqrt.sv @@
// ----------------------------------------------------------------------------
// vn_sqrt: pipelined integer square root
// One result bit per stage by the digit recurrence, truncated root.
// ----------------------------------------------------------------------------
module vn_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  vn_pkg::t_side             i_side,
    input  logic [vn_pkg::SUM_W-1:0]  i_sum,
    output logic                      o_valid,
    output vn_pkg::t_side             o_side,
    output logic [vn_pkg::ROOT_W-1:0] o_root
);
    import vn_pkg::*;

    logic              r_v    [0:ROOT_STEPS-1];
    t_side             r_side [0:ROOT_STEPS-1];
    logic [RAD_W-1:0]  r_rad  [0:ROOT_STEPS-1];
    logic [SREM_W-1:0] r_rem  [0:ROOT_STEPS-1];
    logic [ROOT_W-1:0] r_root [0:ROOT_STEPS-1];

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        logic              p_v;
        t_side             p_side;
        logic [RAD_W-1:0]  p_rad;
        logic [SREM_W-1:0] p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SREM_W+1:0] n_shift;
        logic [SREM_W+1:0] n_trial;
        logic              n_fit;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            assign p_rad  = {1'b0, i_sum};
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        always_comb begin
            n_shift = {p_rem, p_rad[RAD_W-1 -: 2]};
            n_trial = {2'b00, p_root, 2'b01};
            n_fit   = (n_shift >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= p_side;
            r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
            r_rem[k]  <= n_fit ? SREM_W'(n_shift - n_trial) : SREM_W'(n_shift);
            r_root[k] <= {p_root[ROOT_W-2:0], n_fit};
        end
    end

    assign o_valid = r_v[ROOT_STEPS-1];
    assign o_side  = r_side[ROOT_STEPS-1];
    assign o_root  = r_root[ROOT_STEPS-1];

endmodule

@@ hw/rtl/vn_div.sv @@
// ----------------------------------------------------------------------------
// vn_div: four-lane pipelined restoring divider
// Divides each component magnitude, scaled by 2^30, by the shared length,
// one quotient bit per stage, then applies sign and the zero-vector case.
// ----------------------------------------------------------------------------
module vn_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  vn_pkg::t_side             i_side,
    input  logic [vn_pkg::ROOT_W-1:0] i_root,
    output logic                      o_valid,
    output vn_pkg::t_vec_out          o_res
);
    import vn_pkg::*;

    logic                        r_v    [0:DIV_STEPS-1];
    t_side                       r_side [0:DIV_STEPS-1];
    logic [ROOT_W-1:0]           r_len  [0:DIV_STEPS-1];
    logic [LANES-1:0][DREM_W-1:0] r_rem [0:DIV_STEPS-1];
    logic [LANES-1:0][QUO_W-1:0]  r_quo [0:DIV_STEPS-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                         p_v;
        t_side                        p_side;
        logic [ROOT_W-1:0]            p_len;
        logic [LANES-1:0][DREM_W-1:0] p_rem;
        logic [LANES-1:0][QUO_W-1:0]  p_quo;
        logic [LANES-1:0][DREM_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0]  n_quo;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            assign p_len  = i_root;
            assign p_quo  = '0;
            for (genvar l = 0; l < LANES; l++) begin : g_init
                assign p_rem[l] = DREM_W'(i_side.mag[l] >> 1);
            end
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_side = r_side[k-1];
            assign p_len  = r_len[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
        end

        // The scaled dividend has only its lowest magnitude bit below the
        // initial remainder; every later bit shifted in is zero.
        always_comb begin
            logic [DREM_W:0] s_shift;
            logic            s_fit;
            for (int l = 0; l < LANES; l++) begin
                s_shift  = {p_rem[l], (k == 0) ? p_side.mag[l][0] : 1'b0};
                s_fit    = (s_shift >= {1'b0, p_len});
                n_rem[l] = s_fit ? DREM_W'(s_shift - {1'b0, p_len}) : DREM_W'(s_shift);
                n_quo[l] = {p_quo[l][QUO_W-2:0], s_fit};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= p_side;
            r_len[k]  <= p_len;
            r_rem[k]  <= n_rem;
            r_quo[k]  <= n_quo;
        end
    end

    logic                         r_out_v;
    t_vec_out                     r_out;
    logic                         n_zero;
    logic [LANES-1:0][COMP_W-1:0] n_unit;

    always_comb begin
        logic [COMP_W-1:0] s_q;
        n_zero = (r_len[DIV_STEPS-1] == '0);
        for (int l = 0; l < LANES; l++) begin
            s_q = COMP_W'(r_quo[DIV_STEPS-1][l]);
            if (n_zero) begin
                n_unit[l] = '0;
            end else if (r_side[DIV_STEPS-1].neg[l]) begin
                n_unit[l] = ~s_q + 1'b1;
            end else begin
                n_unit[l] = s_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.unit_x      <= n_unit[3];
        r_out.unit_y      <= n_unit[2];
        r_out.unit_z      <= n_unit[1];
        r_out.unit_w      <= n_unit[0];
        r_out.magnitude   <= MAG_W'(r_len[DIV_STEPS-1]);
        r_out.zero_length <= n_zero;
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

@@ test/vector4_normalize_checker.sv @@
// ----------------------------------------------------------------------------
// vector4_normalize_checker: result predictor and comparator
// Watches the input and result channels of the normalizer, computes the
// expected length and unit vector of every accepted vector and compares.
// ----------------------------------------------------------------------------
module vector4_normalize_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  vn_pkg::t_vec_in  i_vec,
    input  logic             i_valid,
    input  vn_pkg::t_vec_out i_res,
    output int               o_errors,
    output int               o_pending,
    output int               o_results
);
    import vn_pkg::*;

    t_vec_out expected_q[$];

    // Integer square root, truncated, of a value up to 2^64.
    function automatic logic [32:0] floor_root(logic [64:0] s);
        logic [32:0] r;
        logic [32:0] t;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            t = r | (33'd1 << b);
            if ({66'd0, t} * {66'd0, t} <= {34'd0, s}) r = t;
        end
        return r;
    endfunction

    function automatic logic [31:0] unit_of(logic [31:0] c, logic [32:0] len);
        logic [31:0] a;
        logic [63:0] q;
        a = c[31] ? (32'd0 - c) : c;
        q = ({32'd0, a} << 30) / {31'd0, len};
        return c[31] ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    function automatic t_vec_out normalize(t_vec_in v);
        t_vec_out r;
        logic [64:0] s;
        logic [31:0] c [4];
        logic [31:0] a;
        c[0] = v.comp_x; c[1] = v.comp_y; c[2] = v.comp_z; c[3] = v.comp_w;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            a = c[i][31] ? (32'd0 - c[i]) : c[i];
            s += {33'd0, a} * {33'd0, a};
        end
        r.magnitude = floor_root(s);
        r.zero_length = (r.magnitude == 0);
        if (r.zero_length) begin
            r.unit_x = v.comp_x; r.unit_y = v.comp_y;
            r.unit_z = v.comp_z; r.unit_w = v.comp_w;
        end else begin
            r.unit_x = unit_of(c[0], r.magnitude);
            r.unit_y = unit_of(c[1], r.magnitude);
            r.unit_z = unit_of(c[2], r.magnitude);
            r.unit_w = unit_of(c[3], r.magnitude);
        end
        return r;
    endfunction

    always_comb o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_vec_out e;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_start && !i_busy) expected_q.push_back(normalize(i_vec));
            if (i_valid) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10) $display("unexpected result %p", i_res);
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_res) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("mismatch: expected %p, got %p", e, i_res);
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_vector4_normalize.sv @@
// ----------------------------------------------------------------------------
// tb_vector4_normalize: testbench for the 4D vector normalizer
// Drives directed corner vectors and then random ones with random sender
// gaps; a checker module beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_vector4_normalize;
    import vn_pkg::*;

    localparam int LATENCY   = 69;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 750;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_vec_in  i_vec;
    logic     o_valid;
    t_vec_out o_res;
    int       errors;
    int       pending;
    int       results;
    int       sent;
    int       idle_cycles;
    int       gap_pct;

    vector4_normalize DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_vec(i_vec), .o_valid(o_valid), .o_res(o_res)
    );

    vector4_normalize_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_vec(i_vec), .i_valid(o_valid), .i_res(o_res),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The watchdog counts cycles in which neither channel makes a transfer.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired");
            $display("tb_vector4_normalize: done, errors");
            $finish;
        end
    end

    // Present one vector and hold it until the block takes it. The sender may
    // first idle, following the current gap percentage.
    task automatic send_vector(t_vec_in v);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_vec <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    // Random components with mixed magnitudes, so small vectors (short
    // lengths and coarse quotients) show up as well as full-scale ones.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed($urandom_range(255)) - 128;
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return 32'd0;
            default: return $signed($urandom & 32'h00ff_ffff) - 32'sh0080_0000;
        endcase
    endfunction

    initial begin
        t_vec_in v;
        logic [31:0] corner [6];
        corner = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h0001_0000};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_vec = '0;
        idle_cycles = 0;
        sent = 0;
        gap_pct = 7;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the zero vector, the largest vector of all -2^31,
        // single-axis vectors at both extremes, and all-ones patterns.
        send_vector('{32'h0, 32'h0, 32'h0, 32'h0});
        send_vector('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_vector('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_vector('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        send_vector('{32'h0000_0001, 32'h0, 32'h0, 32'h0});
        send_vector('{32'h0, 32'hffff_ffff, 32'h0, 32'h0});
        send_vector('{32'h0, 32'h0, 32'h8000_0000, 32'h0});
        send_vector('{32'h0, 32'h0, 32'h0, 32'h7fff_ffff});
        send_vector('{32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0});
        send_vector('{32'hfffd_0000, 32'h0, 32'hfffc_0000, 32'h0});
        for (int i = 0; i < 12; i++) begin
            v.comp_x = corner[$urandom_range(5)];
            v.comp_y = corner[$urandom_range(5)];
            v.comp_z = corner[$urandom_range(5)];
            v.comp_w = corner[$urandom_range(5)];
            send_vector(v);
        end

        // Random part in three phases: light sender gaps, heavy gaps, none.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) gap_pct = 74;
            if (i == 2 * N_RANDOM / 3) gap_pct = 0;
            v.comp_x = rand_comp();
            v.comp_y = rand_comp();
            v.comp_z = rand_comp();
            v.comp_w = rand_comp();
            send_vector(v);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("Sent %0d vectors, including zero, full-scale and single-axis cases,", sent);
        $display("and checked %0d results under three sender gap settings.", results);
        if (errors == 0 && pending == 0) begin
            $display("tb_vector4_normalize: done, clean");
        end else begin
            $display("tb_vector4_normalize: done, errors");
        end
        $finish;
    end
endmodule
